### rtl/core/cpds_pkg.sv
package cpds_pkg;

    // Coordinate format and field widths.
    localparam int COORD_BITS   = 20;
    localparam int AXES         = 3;
    localparam int POINTS       = 2;
    localparam int IDENT_W      = 32;
    localparam int OUT_W        = 21;
    localparam int BEST_W       = 43;

    // Magnitude of a per-axis difference fits in COORD_BITS bits.
    localparam int ABS_W        = COORD_BITS;
    localparam int PROD_W       = 2 * ABS_W;
    localparam int SQ_W         = PROD_W + 2;
    localparam int CMP_W        = (SQ_W > BEST_W) ? SQ_W : BEST_W;

    // Default distance of 9999 cm in 1/16 cm steps, and its square.
    localparam int     DEFAULT_CM   = 9999;
    localparam int     STEPS_PER_CM = 16;
    localparam longint DEFAULT_DIST = longint'(DEFAULT_CM) * longint'(STEPS_PER_CM);
    localparam logic [BEST_W-1:0] DEFAULT_SQ = BEST_W'(DEFAULT_DIST * DEFAULT_DIST);

    // Square root unit: two radicand bits per step.
    localparam int ROOT_STEPS = (BEST_W + 1) / 2;
    localparam int ROOT_IN_W  = 2 * ROOT_STEPS;
    localparam int ROOT_W     = ROOT_STEPS;
    localparam int REM_W      = ROOT_W + 2;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    // Decoupling queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = IDENT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_END_X = 2'd0,
        CFG_END_Y = 2'd1,
        CFG_END_Z = 2'd2,
        CFG_IDENT = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ROOT_IDLE,
        ROOT_RUN,
        ROOT_HOLD
    } root_state_t;

    // Reference settings held in the configuration registers.
    typedef struct packed {
        logic [AXES-1:0][COORD_BITS-1:0] end_pt;
        logic [IDENT_W-1:0]              ident;
    } ref_cfg_t;

    // One classified candidate: start magnitudes first, then end magnitudes.
    typedef struct packed {
        logic                               skip;
        logic                               last;
        logic [POINTS*AXES-1:0][ABS_W-1:0]  mag;
    } cand_entry_t;

    // Request from the back end to the root unit.
    typedef struct packed {
        logic              valid;
        logic              counted;
        logic [BEST_W-1:0] value;
    } root_req_t;

    // Magnitude of the difference of two signed coordinates.
    function automatic logic [ABS_W-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] n;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        n = -d;
        return d[COORD_BITS] ? n[ABS_W-1:0] : d[ABS_W-1:0];
    endfunction

endpackage

### rtl/core/cpds_front.sv
module cpds_front (
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cpds_pkg::COORD_BITS-1:0] cand_start_x,
    input  logic [cpds_pkg::COORD_BITS-1:0] cand_start_y,
    input  logic [cpds_pkg::COORD_BITS-1:0] cand_start_z,
    input  logic [cpds_pkg::COORD_BITS-1:0] cand_end_x,
    input  logic [cpds_pkg::COORD_BITS-1:0] cand_end_y,
    input  logic [cpds_pkg::COORD_BITS-1:0] cand_end_z,
    input  logic [cpds_pkg::IDENT_W-1:0]    cand_ident,
    input  logic                           is_last,
    input  cpds_pkg::ref_cfg_t             ref_cfg,
    input  logic                           q_full,
    output logic                           push,
    output cpds_pkg::cand_entry_t          push_data
);
    import cpds_pkg::*;

    logic [AXES-1:0][COORD_BITS-1:0] start_pt;
    logic [AXES-1:0][COORD_BITS-1:0] end_pt;

    assign start_pt = {cand_start_z, cand_start_y, cand_start_x};
    assign end_pt   = {cand_end_z, cand_end_y, cand_end_x};

    // A transaction is taken whenever the queue has room.
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // Classify the candidate and form the per-axis magnitudes.
    always_comb
    begin
        push_data.skip = (cand_ident == ref_cfg.ident);
        push_data.last = is_last;
        for (int a = 0; a < AXES; a++)
        begin
            push_data.mag[a]        = abs_diff(ref_cfg.end_pt[a], start_pt[a]);
            push_data.mag[AXES + a] = abs_diff(ref_cfg.end_pt[a], end_pt[a]);
        end
    end

endmodule

### rtl/core/cpds_queue.sv
module cpds_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cpds_pkg::cand_entry_t push_data,
    output logic                  full,
    input  logic                  pop,
    output cpds_pkg::cand_entry_t pop_data,
    output logic                  not_empty
);
    import cpds_pkg::*;

    cand_entry_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/cpds_back.sv
module cpds_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_not_empty,
    input  cpds_pkg::cand_entry_t q_data,
    output logic                  pop,
    input  logic                  root_busy,
    output cpds_pkg::root_req_t   root_req
);
    import cpds_pkg::*;

    // Square stage.
    logic                                sq_v_reg;
    logic                                sq_skip_reg, sq_last_reg;
    logic [POINTS*AXES-1:0][PROD_W-1:0]  sq_reg;

    // Sum stage.
    logic                                sum_v_reg;
    logic                                sum_skip_reg, sum_last_reg;
    logic [POINTS-1:0][SQ_W-1:0]         sum_reg;

    // Pairwise minimum stage.
    logic                                pick_v_reg;
    logic                                pick_skip_reg, pick_last_reg;
    logic [SQ_W-1:0]                     pick_reg;

    // Running minimum.
    logic [BEST_W-1:0]                   best_reg, best_next;
    logic                                counted_reg, counted_next;
    logic [BEST_W-1:0]                   best_upd;
    logic                                counted_upd;

    // Hold the queue while a last item is in flight or the root unit works.
    assign pop = q_not_empty && !root_busy
              && !(sq_v_reg && sq_last_reg)
              && !(sum_v_reg && sum_last_reg)
              && !(pick_v_reg && pick_last_reg);

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg   <= 1'b0;
            sum_v_reg  <= 1'b0;
            pick_v_reg <= 1'b0;
        end
        else
        begin
            sq_v_reg   <= pop;
            sum_v_reg  <= sq_v_reg;
            pick_v_reg <= sum_v_reg;
        end
    end

    // Per-axis squares, sums and the smaller of the two endpoint squares.
    always_ff @(posedge clk)
    begin
        sq_skip_reg <= q_data.skip;
        sq_last_reg <= q_data.last;
        for (int i = 0; i < POINTS * AXES; i++)
        begin
            sq_reg[i] <= q_data.mag[i] * q_data.mag[i];
        end

        sum_skip_reg <= sq_skip_reg;
        sum_last_reg <= sq_last_reg;
        for (int p = 0; p < POINTS; p++)
        begin
            sum_reg[p] <= SQ_W'(sq_reg[p*AXES]) + SQ_W'(sq_reg[p*AXES + 1])
                        + SQ_W'(sq_reg[p*AXES + 2]);
        end

        pick_skip_reg <= sum_skip_reg;
        pick_last_reg <= sum_last_reg;
        pick_reg      <= (sum_reg[1] < sum_reg[0]) ? sum_reg[1] : sum_reg[0];
    end

    // Minimum update and hand-off of a finished set to the root unit.
    always_comb
    begin
        best_upd    = best_reg;
        counted_upd = counted_reg;
        if (pick_v_reg && !pick_skip_reg)
        begin
            counted_upd = 1'b1;
            if (CMP_W'(pick_reg) < CMP_W'(best_reg))
            begin
                best_upd = BEST_W'(pick_reg);
            end
        end

        root_req.valid   = pick_v_reg && pick_last_reg;
        root_req.counted = counted_upd;
        root_req.value   = best_upd;

        best_next    = best_upd;
        counted_next = counted_upd;
        if (pick_v_reg && pick_last_reg)
        begin
            best_next    = DEFAULT_SQ;
            counted_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg    <= DEFAULT_SQ;
            counted_reg <= 1'b0;
        end
        else
        begin
            best_reg    <= best_next;
            counted_reg <= counted_next;
        end
    end

`ifndef SYNTH
    // The running minimum never rises above the default square.
    assert property (@(posedge clk) disable iff (!rst_n) best_reg <= DEFAULT_SQ)
        else $error("running minimum above default");

    // A finished set is only handed over to an idle root unit.
    assert property (@(posedge clk) disable iff (!rst_n) root_req.valid |-> !root_busy)
        else $error("root request while root unit busy");

    // No item leaves the queue behind a last item still in the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (sq_v_reg && sq_last_reg) |=> !sq_v_reg)
        else $error("item popped behind last item");
`endif

endmodule

### rtl/core/cpds_root.sv
module cpds_root (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cpds_pkg::root_req_t            root_req,
    output logic                           busy,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cpds_pkg::OUT_W-1:0]     min_distance,
    output logic                           any_counted
);
    import cpds_pkg::*;

    root_state_t          state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [ROOT_IN_W-1:0] val_reg, val_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic                 counted_reg, counted_next;
    logic [REM_W-1:0]     rem_shift;
    logic [REM_W-1:0]     trial;

    assign busy         = (state_reg != ROOT_IDLE);
    assign out_valid    = (state_reg == ROOT_HOLD);
    assign min_distance = root_reg[OUT_W-1:0];
    assign any_counted  = counted_reg;

    // One restoring step: bring in two radicand bits, try the next root bit.
    assign rem_shift = {rem_reg[REM_W-3:0], val_reg[ROOT_IN_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        val_next     = val_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        counted_next = counted_reg;
        unique case (state_reg)
            ROOT_IDLE:
            begin
                if (root_req.valid)
                begin
                    state_next   = ROOT_RUN;
                    step_next    = STEP_W'(ROOT_STEPS - 1);
                    val_next     = ROOT_IN_W'(root_req.value);
                    rem_next     = '0;
                    root_next    = '0;
                    counted_next = root_req.counted;
                end
            end
            ROOT_RUN:
            begin
                val_next = {val_reg[ROOT_IN_W-3:0], 2'b00};
                if (rem_shift >= trial)
                begin
                    rem_next  = rem_shift - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (step_reg == '0)
                begin
                    state_next = ROOT_HOLD;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ROOT_HOLD:
            begin
                if (!out_stall)
                begin
                    state_next = ROOT_IDLE;
                end
            end
            default:
            begin
                state_next = ROOT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ROOT_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Datapath of the root iteration and the result register.
    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        counted_reg <= counted_next;
    end

`ifndef SYNTH
    // The last step of the iteration leads to the result being shown.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == ROOT_RUN && step_reg == '0) |=> (state_reg == ROOT_HOLD))
        else $error("root iteration did not finish on its last step");

    // A result never exceeds the default distance.
    assert property (@(posedge clk) disable iff (!rst_n)
                     out_valid |-> (min_distance <= OUT_W'(DEFAULT_DIST)))
        else $error("result above default distance");
`endif

endmodule

### rtl/core/closest_point_distance_search_unit.sv
// Closest endpoint distance search. Program the reference endpoint and the
// reference identifier while the block is idle, then send candidate segments;
// candidates whose identifier equals the reference identifier are ignored. One
// transaction is taken per cycle into a two-entry queue while it has room, and
// the back end drains it at one candidate per cycle through a square, sum and
// minimum pipeline. After a transaction marked last, the back end takes no
// further candidate until that set's result from the iterative square root is
// delivered, which also waits out any output stall. The result is the floor
// square root of the smallest squared distance in 1/16 cm steps, capped at
// 159984 (9999 cm), which is also the result, with any_counted low, when no
// candidate counted.
module closest_point_distance_search_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [cpds_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [cpds_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cpds_pkg::COORD_BITS-1:0] cand_start_x,
    input  logic [cpds_pkg::COORD_BITS-1:0] cand_start_y,
    input  logic [cpds_pkg::COORD_BITS-1:0] cand_start_z,
    input  logic [cpds_pkg::COORD_BITS-1:0] cand_end_x,
    input  logic [cpds_pkg::COORD_BITS-1:0] cand_end_y,
    input  logic [cpds_pkg::COORD_BITS-1:0] cand_end_z,
    input  logic [cpds_pkg::IDENT_W-1:0]    cand_ident,
    input  logic                            is_last,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cpds_pkg::OUT_W-1:0]      min_distance,
    output logic                            any_counted
);
    import cpds_pkg::*;

    ref_cfg_t    ref_cfg_reg;
    logic        q_full;
    logic        push;
    cand_entry_t push_data;
    logic        pop;
    cand_entry_t pop_data;
    logic        q_not_empty;
    logic        root_busy;
    root_req_t   root_req;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                CFG_END_X: ref_cfg_reg.end_pt[0] <= wr_data[COORD_BITS-1:0];
                CFG_END_Y: ref_cfg_reg.end_pt[1] <= wr_data[COORD_BITS-1:0];
                CFG_END_Z: ref_cfg_reg.end_pt[2] <= wr_data[COORD_BITS-1:0];
                CFG_IDENT: ref_cfg_reg.ident     <= wr_data[IDENT_W-1:0];
            endcase
        end
    end

    cpds_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cand_start_x (cand_start_x),
        .cand_start_y (cand_start_y),
        .cand_start_z (cand_start_z),
        .cand_end_x   (cand_end_x),
        .cand_end_y   (cand_end_y),
        .cand_end_z   (cand_end_z),
        .cand_ident   (cand_ident),
        .is_last      (is_last),
        .ref_cfg      (ref_cfg_reg),
        .q_full       (q_full),
        .push         (push),
        .push_data    (push_data)
    );

    cpds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (q_not_empty)
    );

    cpds_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (pop_data),
        .pop         (pop),
        .root_busy   (root_busy),
        .root_req    (root_req)
    );

    cpds_root u_root (
        .clk          (clk),
        .rst_n        (rst_n),
        .root_req     (root_req),
        .busy         (root_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .min_distance (min_distance),
        .any_counted  (any_counted)
    );

endmodule
